// ===== sv/fcau_pkg.sv =====
// ---------------------------------------------------------------------------
// fcau_pkg: shared definitions for the first-fit contiguous allocator
// Field widths, request and status codes, and the scan unit result type.
// ---------------------------------------------------------------------------
package fcau_pkg;

	localparam int WORD_BITS = 32;
	localparam int OFF_W     = 5;
	localparam int RUN_W     = 12;
	localparam int START_W   = 10;
	localparam int SIZE_W    = 11;
	localparam int STATUS_W  = 2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;

	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

	typedef struct packed {
		logic             hit;
		logic [OFF_W-1:0] pos;
		logic [RUN_W-1:0] run;
	} scan_res_t;

endpackage

// ===== sv/fcau_map_ram.sv =====
// ---------------------------------------------------------------------------
// fcau_map_ram: cell map storage
// One word of cell flags per entry, one write and one registered read a cycle.
// ---------------------------------------------------------------------------
module fcau_map_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [fcau_pkg::WORD_BITS-1:0] wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [fcau_pkg::WORD_BITS-1:0] rdata
);
	import fcau_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/fcau_word_scan.sv =====
// ---------------------------------------------------------------------------
// fcau_word_scan: free-run search over one map word
// Extends the run carried in from lower words and finds where it first
// reaches the requested length.
// ---------------------------------------------------------------------------
module fcau_word_scan (
	input  logic [fcau_pkg::WORD_BITS-1:0] word,
	input  logic [fcau_pkg::RUN_W-1:0]     carry,
	input  logic [fcau_pkg::SIZE_W-1:0]    len,
	output fcau_pkg::scan_res_t            res
);
	import fcau_pkg::*;

	logic [RUN_W-1:0] run [WORD_BITS];

	// Each position works out the length of the free run that ends at it, independently of the others.
	always_comb begin
		logic             found;
		logic [OFF_W-1:0] p;
		for (int j = 0; j < WORD_BITS; j++) begin
			found = 1'b0;
			p     = '0;
			for (int b = 0; b < WORD_BITS; b++) begin
				if (b <= j && word[b]) begin
					found = 1'b1;
					p     = OFF_W'(b);
				end
			end
			if (word[j]) begin
				run[j] = '0;
			end else if (found) begin
				run[j] = RUN_W'(j) - RUN_W'(p);
			end else begin
				run[j] = carry + RUN_W'(j) + RUN_W'(1);
			end
		end
	end

	always_comb begin
		res.hit = 1'b0;
		res.pos = '0;
		res.run = run[WORD_BITS-1];
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (run[j] >= RUN_W'(len)) begin
				res.hit = 1'b1;
				res.pos = OFF_W'(j);
			end
		end
	end

endmodule

// ===== sv/first_fit_contiguous_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// first_fit_contiguous_allocator_unit: first-fit allocator over a cell map
// Allocates the lowest run of free cells of a requested size and frees ranges.
// ---------------------------------------------------------------------------
// The map holds CELLS one-bit flags packed 32 to a word in a single-port-write,
// registered-read memory, and one word scan unit walks it a word a cycle.
// After reset the block clears the map word by word and holds s_tready low
// meanwhile. An allocate request reads words upward from word 0 until the
// run is found, then rewrites each word the new block touches with a
// read-modify-write that streams one word a cycle, and passes through a
// finish state that hands the result to the output register once that
// register is free. A free request only does the read-modify-write sweep
// over the words it covers. A size of zero, an allocate larger than the map
// or a free starting past the map goes straight to the finish state. Only
// one request is in flight at a time; the result sits in an output register
// so that the next request can be taken while it waits on m_tready.
module first_fit_contiguous_allocator_unit #(
	parameter int CELLS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [9:0] start_index, [20:10] block_size, [23:21] zero
	input  logic [0:0]  s_tuser,  // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [9:0] block_start, [15:10] zero
	output logic [1:0]  m_tuser   // [1:0] status
);
	import fcau_pkg::*;

	localparam int WORDS     = (CELLS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW        = ($clog2(CELLS + 1) > 12) ? $clog2(CELLS + 1) : 12;
	localparam int LAST_BITS = CELLS - (WORDS - 1) * WORD_BITS;

	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
	localparam logic [CW-1:0] CELLS_CW  = CW'(CELLS);
	// Bits of the top word that lie beyond the map look used to the scan.
	localparam logic [WORD_BITS-1:0] PAD_MASK = ~(WORD_ONES >> (WORD_BITS - LAST_BITS));

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_RMW  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	function automatic logic [AW-1:0] word_of(input logic [CW-1:0] c);
		logic [CW-1:0] s;
		s = c >> OFF_W;
		return s[AW-1:0];
	endfunction

	logic [2:0]          state_q;
	logic [AW-1:0]       ptr_q;
	logic                more_q;
	logic                rvalid_q;
	logic [AW-1:0]       rword_q;
	logic [RUN_W-1:0]    carry_q;
	logic [SIZE_W-1:0]   len_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [AW-1:0]       last_word_q;
	logic                clear_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [START_W-1:0]  res_start_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [START_W-1:0]  out_start_q;

	logic [START_W-1:0]   in_start;
	logic [SIZE_W-1:0]    in_size;
	logic                 in_accept;
	logic [CW-1:0]        free_sum;
	logic [CW-1:0]        free_hi;
	logic [CW-1:0]        alloc_lo;
	logic [CW-1:0]        alloc_hi;
	logic [CW-1:0]        hi_last;
	logic [OFF_W-1:0]     hi_off;
	logic [WORD_BITS-1:0] mask_lo;
	logic [WORD_BITS-1:0] mask_hi;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] scan_word;
	logic                 out_free;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        end_word;
	scan_res_t            sres;

	assign in_start  = s_tdata[START_W-1:0];
	assign in_size   = s_tdata[START_W+SIZE_W-1:START_W];
	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;

	// Free ranges are clipped at the top of the map.
	assign free_sum = CW'(in_start) + CW'(in_size);
	assign free_hi  = (free_sum > CELLS_CW) ? CELLS_CW : free_sum;

	// The run found ends at the hit position of the word being examined.
	assign alloc_lo = CW'({rword_q, sres.pos}) + CW'(1) - CW'(len_q);
	assign alloc_hi = alloc_lo + CW'(len_q);

	assign scan_word = rdata | ((rword_q == LAST_WORD) ? PAD_MASK : '0);

	fcau_word_scan u_scan (
		.word  (scan_word),
		.carry (carry_q),
		.len   (len_q),
		.res   (sres)
	);

	// Cells of the current word that fall inside [lo, hi).
	assign hi_last = hi_q - CW'(1);
	assign hi_off  = hi_last[OFF_W-1:0];
	assign mask_lo = (rword_q == word_of(lo_q)) ? (WORD_ONES << lo_q[OFF_W-1:0]) : WORD_ONES;
	assign mask_hi = (rword_q == last_word_q) ? (WORD_ONES >> (OFF_W'(WORD_BITS - 1) - hi_off))
	                                          : WORD_ONES;
	assign mask    = mask_lo & mask_hi;

	assign end_word = (state_q == S_SCAN) ? LAST_WORD : last_word_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rword_q;
		mem_wdata = clear_q ? (rdata & ~mask) : (rdata | mask);
		mem_re    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = '0;
			end
			S_SCAN: begin
				mem_re = more_q && !(rvalid_q && sres.hit);
			end
			S_RMW: begin
				mem_we = rvalid_q;
				mem_re = more_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	fcau_map_ram #(
		.DEPTH (WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	assign out_free = !out_valid_q || m_tready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			ptr_q    <= '0;
			more_q   <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= mem_re;
			if (mem_re) begin
				ptr_q <= ptr_q + AW'(1);
				if (ptr_q == end_word) begin
					more_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_CLR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						if (s_tuser[0] == REQ_FREE) begin
							if (in_size == '0 || CW'(in_start) >= CELLS_CW) begin
								state_q <= S_FIN;
							end else begin
								ptr_q   <= word_of(CW'(in_start));
								more_q  <= 1'b1;
								state_q <= S_RMW;
							end
						end else begin
							if (in_size == '0 || CW'(in_size) > CELLS_CW) begin
								state_q <= S_FIN;
							end else begin
								ptr_q   <= '0;
								more_q  <= 1'b1;
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (rvalid_q) begin
						if (sres.hit) begin
							ptr_q   <= word_of(alloc_lo);
							more_q  <= 1'b1;
							state_q <= S_RMW;
						end else if (rword_q == LAST_WORD) begin
							state_q <= S_FIN;
						end
					end
				end
				S_RMW: begin
					if (rvalid_q && rword_q == last_word_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rword_q <= ptr_q;
		end
		if (state_q == S_IDLE && in_accept) begin
			len_q       <= in_size;
			carry_q     <= '0;
			lo_q        <= CW'(in_start);
			hi_q        <= free_hi;
			last_word_q <= word_of(free_hi - CW'(1));
			clear_q     <= (s_tuser[0] == REQ_FREE);
			res_start_q <= '0;
			res_status_q <= (s_tuser[0] == REQ_FREE) ? ST_FREED : ST_NO_SPACE;
		end
		if (state_q == S_SCAN && rvalid_q) begin
			carry_q <= sres.run;
			if (sres.hit) begin
				lo_q         <= alloc_lo;
				hi_q         <= alloc_hi;
				last_word_q  <= rword_q;
				res_status_q <= ST_ALLOCATED;
				res_start_q  <= alloc_lo[START_W-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'd0, out_start_q};

endmodule

// ===== sv/fcau_checker.sv =====
// ---------------------------------------------------------------------------
// fcau_checker: port-level checks for the allocator
// Watches the request and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
module fcau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import fcau_pkg::*;

	// A result waiting on the sink stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one request is worked on at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// Status is always one of the defined codes.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_ALLOCATED || m_tuser == ST_NO_SPACE ||
		              m_tuser == ST_FREED))
		else $error("undefined status code");

	// A block start is only reported for a successful allocation.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_ALLOCATED |-> m_tdata == 16'd0)
		else $error("block start set without allocation");

endmodule

bind first_fit_contiguous_allocator_unit fcau_checker u_fcau_checker (.*);

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for first_fit_contiguous_allocator_unit
// Drives allocate and free requests into the stream port and predicts each
// status and block start from a private copy of the cell map.
// ---------------------------------------------------------------------------
module testbench;

	import fcau_pkg::*;

	localparam int MAP_CELLS        = 1024;
	localparam int RESET_CYCLES     = 12;
	localparam int HOLD_CYCLES      = 400;
	localparam int DRAIN_CYCLES     = 100;
	localparam int WATCHDOG_LIMIT   = 4000;

	// Receiver behaviours; the receiver switches between them at random.
	localparam int RX_ALWAYS  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_SPARSE  = 2;
	localparam int RX_PATTERN = 3;

	typedef struct packed {
		logic               kind;
		logic [START_W-1:0] start_index;
		logic [SIZE_W-1:0]  block_size;
	} alloc_request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  block_start;
	} alloc_result_t;

	// A block handed out by the allocator that the stimulus may free later.
	typedef struct {
		int first;
		int length;
	} live_block_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [9:0] start_index, [20:10] block_size, [23:21] zero
	logic [0:0]  s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [9:0] block_start, [15:10] zero
	logic [1:0]  m_tuser;   // [1:0] status

	// Private copy of the map: one bit per cell, 1 means used.
	bit            cell_map [MAP_CELLS];
	alloc_result_t pending_results [$];
	live_block_t   live_blocks [$];
	int            mismatches = 0;
	int            idle_cycles = 0;
	int            burst_left = 0;
	bit            sender_gaps = 1'b1;
	bit            hold_requested = 1'b0;

	first_fit_contiguous_allocator_unit #(
		.CELLS(MAP_CELLS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// Works out the result of one request and applies it to the private map.
	// An allocate scans upward from cell 0 for the first run of free cells of
	// the requested length; a free clears the range, clipped at the map's end.
	function automatic alloc_result_t predict_allocation(input alloc_request_t req);
		alloc_result_t res;
		int run_len;
		int run_first;
		int stop;
		int i;
		int j;
		res.status      = ST_NO_SPACE;
		res.block_start = '0;
		if (req.kind == REQ_ALLOC) begin
			run_len   = 0;
			run_first = 0;
			if (req.block_size != 0 && req.block_size <= MAP_CELLS) begin
				for (i = 0; i < MAP_CELLS && res.status != ST_ALLOCATED; i++) begin
					if (!cell_map[i]) begin
						if (run_len == 0)
							run_first = i;
						run_len++;
						if (run_len == req.block_size) begin
							for (j = run_first; j <= i; j++)
								cell_map[j] = 1'b1;
							res.status      = ST_ALLOCATED;
							res.block_start = run_first[START_W-1:0];
						end
					end else begin
						run_len = 0;
					end
				end
			end
		end else begin
			stop = int'(req.start_index) + int'(req.block_size);
			if (stop > MAP_CELLS)
				stop = MAP_CELLS;
			for (i = int'(req.start_index); i < stop; i++)
				cell_map[i] = 1'b0;
			res.status = ST_FREED;
		end
		return res;
	endfunction

	// Offers one request and waits for the handshake. The valid line is left
	// high so that a following request goes out back to back; it drops only
	// when a gap between bursts is taken or when the bench waits for results.
	task automatic send_request(input logic kind, input int start, input int length,
	                            output alloc_result_t predicted);
		alloc_request_t req;
		int gap;
		req.kind        = kind;
		req.start_index = start[START_W-1:0];
		req.block_size  = length[SIZE_W-1:0];
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, req.block_size, req.start_index};
		s_tuser  <= req.kind;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_allocation(req);
		pending_results.push_back(predicted);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (sender_gaps && $urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 15);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Allocates a block and remembers it for a later free if it was granted.
	task automatic allocate_block(input int length, output alloc_result_t res);
		live_block_t blk;
		send_request(REQ_ALLOC, $urandom_range(0, MAP_CELLS - 1), length, res);
		if (res.status == ST_ALLOCATED) begin
			blk.first  = int'(res.block_start);
			blk.length = length;
			live_blocks.push_back(blk);
		end
	endtask

	// Frees one of the remembered blocks, picked at random.
	task automatic free_live_block();
		alloc_result_t res;
		int idx;
		idx = $urandom_range(0, live_blocks.size() - 1);
		send_request(REQ_FREE, live_blocks[idx].first, live_blocks[idx].length, res);
		live_blocks.delete(idx);
	endtask

	// Stops offering requests and waits until every predicted result is back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of both fields and the corner cases of the allocator: zero and
	// oversized allocations, a full map, reuse of a hole, frees that reach past
	// the end of the map, empty frees and frees of cells that are already free.
	task automatic test_directed();
		alloc_result_t res;
		send_request(REQ_ALLOC, MAP_CELLS - 1, 0, res);
		send_request(REQ_ALLOC, 0, MAP_CELLS, res);
		send_request(REQ_ALLOC, 0, 1, res);
		send_request(REQ_FREE, 0, MAP_CELLS, res);
		send_request(REQ_ALLOC, 0, 2047, res);
		send_request(REQ_ALLOC, 0, MAP_CELLS + 1, res);
		send_request(REQ_ALLOC, 777, 4, res);
		send_request(REQ_ALLOC, 0, 4, res);
		send_request(REQ_ALLOC, 0, 4, res);
		send_request(REQ_FREE, 4, 4, res);
		send_request(REQ_ALLOC, 0, 3, res);
		send_request(REQ_ALLOC, 0, 2, res);
		send_request(REQ_ALLOC, 0, 1, res);
		send_request(REQ_FREE, 5, 0, res);
		send_request(REQ_FREE, 100, 50, res);
		send_request(REQ_FREE, MAP_CELLS - 1, 2047, res);
		send_request(REQ_ALLOC, 0, 1000, res);
		send_request(REQ_ALLOC, 0, 11, res);
		send_request(REQ_ALLOC, 0, 10, res);
		send_request(REQ_FREE, 0, 2047, res);
		send_request(REQ_ALLOC, 0, MAP_CELLS - 1, res);
		send_request(REQ_ALLOC, 0, 1, res);
		send_request(REQ_FREE, MAP_CELLS - 1, 1, res);
		send_request(REQ_FREE, 512, 511, res);
		send_request(REQ_FREE, 0, MAP_CELLS, res);
		wait_drained();
	endtask

	// Mostly well-formed traffic: small allocations and frees of blocks that
	// were really handed out, so the map fragments and the scan has to skip
	// used runs. The rest is noise: random ranges freed, zero, huge and
	// oversized allocations.
	task automatic test_random_churn(input int count);
		alloc_result_t res;
		int pick;
		int length;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_request(REQ_FREE, $urandom_range(0, MAP_CELLS - 1),
				             $urandom_range(0, 2047), res);
			end else if (pick < 12) begin
				case ($urandom_range(0, 2))
					0:       length = 0;
					1:       length = $urandom_range(MAP_CELLS + 1, 2047);
					default: length = $urandom_range(256, MAP_CELLS);
				endcase
				allocate_block(length, res);
			end else if (live_blocks.size() > 0 && (pick < 50 || live_blocks.size() > 60)) begin
				free_live_block();
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					length = $urandom_range(1, 32);
				else if (pick < 9)
					length = $urandom_range(33, 256);
				else
					length = $urandom_range(257, MAP_CELLS);
				allocate_block(length, res);
			end
		end
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while requests keep coming
	// back to back, so the result register fills and the input has to stall.
	task automatic test_backpressure();
		alloc_result_t res;
		sender_gaps    = 1'b0;
		hold_requested = 1'b1;
		repeat (16)
			allocate_block($urandom_range(1, 64), res);
		sender_gaps = 1'b1;
		wait_drained();
	endtask

	// Fills the map with small blocks until an allocation fails, punches holes
	// by freeing half of them, refills the holes with larger blocks, then
	// frees everything and checks that the whole map is one run again.
	task automatic test_fill_and_drain();
		alloc_result_t res;
		int guard;
		send_request(REQ_FREE, 0, MAP_CELLS, res);
		live_blocks.delete();
		guard = 0;
		do begin
			allocate_block($urandom_range(1, 8), res);
			guard++;
		end while (res.status == ST_ALLOCATED && guard < 600);
		repeat (live_blocks.size() / 2)
			free_live_block();
		guard = 0;
		do begin
			allocate_block($urandom_range(2, 16), res);
			guard++;
		end while (res.status == ST_ALLOCATED && guard < 300);
		while (live_blocks.size() > 0)
			free_live_block();
		send_request(REQ_ALLOC, 0, MAP_CELLS, res);
		send_request(REQ_FREE, 0, MAP_CELLS, res);
		wait_drained();
	endtask

	// Receiver: switches between always ready, random stalls, sparse readiness
	// and a fixed duty cycle. A long hold-off is taken when the stimulus asks.
	initial begin : receiver
		int mode;
		int mode_left;
		int rx_cycle;
		mode      = RX_ALWAYS;
		mode_left = 0;
		rx_cycle  = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				hold_requested = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(RX_ALWAYS, RX_PATTERN);
					mode_left = $urandom_range(40, 400);
				end
				mode_left--;
				rx_cycle++;
				case (mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ((rx_cycle % 7) < 4);
				endcase
			end
		end
	end

	// Every result taken from the block is matched against the oldest
	// prediction; the padding above the block start must read as zero.
	always @(posedge clk) begin
		alloc_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d, m_tdata 0x%04h",
				         $time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tuser !== exp_res.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
					         $time, exp_res.status, m_tuser);
					mismatches++;
				end
				if (m_tdata !== {{(16 - START_W){1'b0}}, exp_res.block_start}) begin
					$display("%0t: m_tdata mismatch: expected 0x%04h, actual 0x%04h",
					         $time, {{(16 - START_W){1'b0}}, exp_res.block_start}, m_tdata);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: ends the run if no request or result moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : run_tests
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_churn(700);
		test_backpressure();
		test_fill_and_drain();
		test_random_churn(250);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
